/* hw/rtl/tglc_pkg.sv */
// ----------------------------------------------------------------------------
// tglc_pkg
// shared codes and types for the lane change grid core
// ----------------------------------------------------------------------------
package tglc_pkg;

    localparam int CFG_W  = 16;
    localparam int CELL_W = 16;

    localparam logic [2:0] CMD_PLACE   = 3'd0;
    localparam logic [2:0] CMD_REMOVE  = 3'd1;
    localparam logic [2:0] CMD_GAP     = 3'd2;
    localparam logic [2:0] CMD_CHANGE  = 3'd3;
    localparam logic [2:0] CMD_ADVANCE = 3'd4;

    localparam logic [2:0] CFG_ROAD_LENGTH = 3'd0;
    localparam logic [2:0] CFG_LANES_USED  = 3'd1;
    localparam logic [2:0] CFG_MAX_SPEED   = 3'd2;
    localparam logic [2:0] CFG_THRESHOLD   = 3'd3;
    localparam logic [2:0] CFG_PERIODIC    = 3'd4;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_DISPATCH,
        ST_BACK,
        ST_MK_START,
        ST_MK_RD,
        ST_MK_WR,
        ST_HW,
        ST_SC_RD,
        ST_SC_EV,
        ST_DEC,
        ST_TC_RD,
        ST_TC_EV,
        ST_ADV,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/tglc_grid_mem.sv */
// ----------------------------------------------------------------------------
// tglc_grid_mem
// road cell memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tglc_grid_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/traffic_grid_lane_change_core.sv */
// ----------------------------------------------------------------------------
// traffic_grid_lane_change_core
// lane by cell road grid of marker sums with place, remove, gap, lane change
// and advance commands, sequenced over one grid memory
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       i_valid / o_stall     i_cmd .. i_advance
//  out      o_valid / i_stall     o_new_pos, o_new_lane, o_changed, o_gap
//  cfg      i_cfg_we              i_cfg_idx, i_cfg_data
//
//  after reset the grid is cleared, one cell a cycle
//  one command at a time; each grid access is a read then a write or a check
//  on the one grid memory; a command first reduces its front position
//  modulo the road length by shift and subtract, then marks or scans cells
//  o_stall is high during the clear and while a command runs
//  a held result does not block intake
// ----------------------------------------------------------------------------
module traffic_grid_lane_change_core #(
    parameter int LANES      = 4,
    parameter int ROAD_CELLS = 1024,
    parameter int MAX_WIDTH  = 2,
    parameter int MAX_LENGTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [9:0]  i_front_pos,
    input  logic [1:0]  i_left_lane,
    input  logic [3:0]  i_speed,
    input  logic [3:0]  i_body_length,
    input  logic [1:0]  i_body_width,
    input  logic [14:0] i_tag,
    input  logic [15:0] i_rand_req,
    input  logic [3:0]  i_advance,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_new_pos,
    output logic [1:0]  o_new_lane,
    output logic        o_changed,
    output logic [3:0]  o_gap,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int PW    = $clog2(ROAD_CELLS);
    localparam int LW    = $clog2(ROAD_CELLS + 1);
    localparam int VW    = ($clog2(ROAD_CELLS + 16) > 10) ? $clog2(ROAD_CELLS + 16) : 10;
    localparam int MW    = VW + LW;
    localparam int KW    = $clog2(VW);
    localparam int DEPTH = LANES * ROAD_CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LAW   = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NLW   = $clog2(LANES + 1);
    localparam int BLW   = $clog2(MAX_LENGTH + 1);
    localparam int BWW   = $clog2(MAX_WIDTH + 1);
    localparam int TNW   = $clog2(MAX_LENGTH + 16);
    localparam int HIW   = $clog2(3 * MAX_WIDTH + 1);
    localparam int SLW   = $clog2(LANES + 4 * MAX_WIDTH + 4) + 1;
    localparam int DW    = tglc_pkg::CELL_W;

    // configuration
    logic [10:0] r_cfg_len;
    logic [2:0]  r_cfg_lanes;
    logic [3:0]  r_cfg_ms;
    logic [15:0] r_cfg_thr;
    logic        r_cfg_per;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= 11'd1024;
            r_cfg_lanes <= 3'd4;
            r_cfg_ms    <= 4'd5;
            r_cfg_thr   <= 16'd0;
            r_cfg_per   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tglc_pkg::CFG_ROAD_LENGTH: r_cfg_len   <= i_cfg_data[10:0];
                tglc_pkg::CFG_LANES_USED:  r_cfg_lanes <= i_cfg_data[2:0];
                tglc_pkg::CFG_MAX_SPEED:   r_cfg_ms    <= i_cfg_data[3:0];
                tglc_pkg::CFG_THRESHOLD:   r_cfg_thr   <= i_cfg_data;
                tglc_pkg::CFG_PERIODIC:    r_cfg_per   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [LW-1:0]         len_c;
    logic [PW-1:0]         lenm1;
    logic [NLW-1:0]        nl_u;
    logic signed [SLW-1:0] nl_s;

    assign len_c = (r_cfg_len == 11'd0) ? LW'(1) :
                   (32'(r_cfg_len) > ROAD_CELLS) ? LW'(ROAD_CELLS) : LW'(r_cfg_len);
    assign lenm1 = PW'(len_c - LW'(1));
    assign nl_u  = (r_cfg_lanes == 3'd0) ? NLW'(1) :
                   (32'(r_cfg_lanes) > LANES) ? NLW'(LANES) : NLW'(r_cfg_lanes);
    assign nl_s  = signed'(SLW'(nl_u));

    // control and item registers
    tglc_pkg::t_state r_state, n_state, r_ret, n_ret;

    logic [AW-1:0]         r_clr, n_clr;
    logic [2:0]            r_cmd, n_cmd;
    logic [PW-1:0]         r_front, n_front;
    logic signed [SLW-1:0] r_lane, n_lane;
    logic [3:0]            r_spd, n_spd;
    logic [BLW-1:0]        r_blen, n_blen;
    logic [BWW-1:0]        r_bw, n_bw;
    logic [14:0]           r_tag, n_tag;
    logic [15:0]           r_rnd, n_rnd;
    logic [3:0]            r_adv, n_adv;
    logic [VW-1:0]         r_mv, n_mv;
    logic [KW-1:0]         r_mk, n_mk;
    logic [PW-1:0]         r_ptr, n_ptr;
    logic [BLW-1:0]        r_bk, n_bk;
    logic [DW-1:0]         r_delta, n_delta;
    logic [BLW-1:0]        r_k, n_k;
    logic [BWW-1:0]        r_j, n_j;
    logic                  r_second, n_second;
    logic                  r_changed, n_changed;
    logic                  r_right, n_right;
    logic signed [SLW-1:0] r_tl, n_tl;
    logic [3:0]            r_cnt, n_cnt;
    logic signed [SLW-1:0] r_ln, n_ln;
    logic [HIW-1:0]        r_i, n_i;
    logic [HIW-1:0]        r_iend, n_iend;
    logic [3:0]            r_prev, n_prev;
    logic [HIW-1:0]        r_best, n_best;
    logic [4:0]            r_bestv, n_bestv;
    logic [3:0]            r_gap, n_gap;
    logic [TNW-1:0]        r_tn, n_tn;
    logic                  r_ovalid, n_ovalid;
    logic [9:0]            r_opos, n_opos;
    logic [1:0]            r_olane, n_olane;
    logic                  r_ochg, n_ochg;
    logic [3:0]            r_ogap, n_ogap;

    // memory port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_addr;
    logic [DW-1:0]         mem_wdata, mem_rdata;
    logic signed [SLW-1:0] mem_lane;

    tglc_grid_mem #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (DW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_addr),
        .o_rdata(mem_rdata)
    );

    // helpers
    logic [PW-1:0]         ptr_inc, ptr_dec, front_inc;
    logic [MW-1:0]         mod_sh;
    logic [VW-1:0]         mv_step;
    logic signed [SLW-1:0] l_cur, l_mk;
    logic                  l_onroad, l_own;
    logic [HIW-1:0]        size_c, centre_c;
    logic [DW-1:0]         neg_c;
    logic [VW-1:0]         adv_sum;
    logic [BLW-1:0]        blen_in;
    logic [BWW-1:0]        bw_in;
    logic                  hw_fin;
    logic [3:0]            hw_v;
    logic [4:0]            cand1, b1v;
    logic [HIW-1:0]        b1;
    logic                  chg_ok, go_left, go_right;

    assign ptr_inc   = (r_ptr == lenm1) ? '0 : r_ptr + PW'(1);
    assign ptr_dec   = (r_ptr == '0) ? lenm1 : r_ptr - PW'(1);
    assign front_inc = (r_front == lenm1) ? '0 : r_front + PW'(1);
    assign mod_sh    = MW'(len_c) << r_mk;
    assign mv_step   = (MW'(r_mv) >= mod_sh) ? VW'(MW'(r_mv) - mod_sh) : r_mv;
    assign l_cur     = r_lane - SLW'(r_bw) + SLW'(r_i);
    assign l_mk      = r_lane + SLW'(r_j);
    assign l_onroad  = (l_cur >= 0) && (l_cur < nl_s);
    assign l_own     = (r_i >= HIW'(r_bw)) && (r_i < HIW'(2 * r_bw));
    assign size_c    = HIW'(3 * r_bw);
    assign centre_c  = HIW'((3 * r_bw - 1) >> 1);
    assign neg_c     = DW'(0) - DW'(r_tag);
    assign adv_sum   = VW'(r_front) + VW'(r_adv);
    assign blen_in   = (i_body_length == 4'd0) ? BLW'(1) :
                       (32'(i_body_length) > MAX_LENGTH) ? BLW'(MAX_LENGTH) :
                       BLW'(i_body_length);
    assign bw_in     = (i_body_width == 2'd0) ? BWW'(1) :
                       (32'(i_body_width) > MAX_WIDTH) ? BWW'(MAX_WIDTH) :
                       BWW'(i_body_width);

    assign cand1 = 5'(r_prev) + ((r_bw > BWW'(1)) ? 5'(hw_v) : 5'd0);
    always_comb begin
        b1  = r_best;
        b1v = r_bestv;
        if (r_i != '0 && (r_i == HIW'(1) || cand1 > r_bestv)) begin
            b1  = r_i - HIW'(1);
            b1v = cand1;
        end
    end

    assign chg_ok   = (r_rnd <= r_cfg_thr) && (r_gap <= r_spd) && (r_spd < r_cfg_ms);
    assign go_left  = (r_best < centre_c) && (r_lane > 0) && (r_lane - SLW'(1) < nl_s);
    assign go_right = (r_best > centre_c) && (r_lane + SLW'(r_bw) < nl_s);

    always_comb begin
        unique case (r_state)
            tglc_pkg::ST_MK_RD, tglc_pkg::ST_MK_WR: mem_lane = l_mk;
            tglc_pkg::ST_TC_RD, tglc_pkg::ST_TC_EV: mem_lane = r_tl;
            default:                                mem_lane = r_ln;
        endcase
    end

    assign mem_addr = AW'(int'(LAW'(unsigned'(mem_lane))) * ROAD_CELLS + int'(r_ptr));

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_clr     = r_clr;
        n_cmd     = r_cmd;
        n_front   = r_front;
        n_lane    = r_lane;
        n_spd     = r_spd;
        n_blen    = r_blen;
        n_bw      = r_bw;
        n_tag     = r_tag;
        n_rnd     = r_rnd;
        n_adv     = r_adv;
        n_mv      = r_mv;
        n_mk      = r_mk;
        n_ptr     = r_ptr;
        n_bk      = r_bk;
        n_delta   = r_delta;
        n_k       = r_k;
        n_j       = r_j;
        n_second  = r_second;
        n_changed = r_changed;
        n_right   = r_right;
        n_tl      = r_tl;
        n_cnt     = r_cnt;
        n_ln      = r_ln;
        n_i       = r_i;
        n_iend    = r_iend;
        n_prev    = r_prev;
        n_best    = r_best;
        n_bestv   = r_bestv;
        n_gap     = r_gap;
        n_tn      = r_tn;
        n_ovalid  = r_ovalid && i_stall;
        n_opos    = r_opos;
        n_olane   = r_olane;
        n_ochg    = r_ochg;
        n_ogap    = r_ogap;
        mem_we    = 1'b0;
        mem_waddr = mem_addr;
        mem_wdata = mem_rdata + r_delta;
        hw_fin    = 1'b0;
        hw_v      = r_cnt;

        unique case (r_state)
            tglc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = tglc_pkg::ST_IDLE;
                end
            end
            tglc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_cmd     = i_cmd;
                    n_lane    = signed'(SLW'(i_left_lane));
                    n_spd     = i_speed;
                    n_blen    = blen_in;
                    n_bw      = bw_in;
                    n_tag     = i_tag;
                    n_rnd     = i_rand_req;
                    n_adv     = i_advance;
                    n_mv      = VW'(i_front_pos);
                    n_mk      = KW'(VW - 1);
                    n_second  = 1'b0;
                    n_changed = 1'b0;
                    n_state   = tglc_pkg::ST_MOD;
                end
            end
            tglc_pkg::ST_MOD: begin
                n_mv = mv_step;
                n_mk = r_mk - KW'(1);
                if (r_mk == '0) begin
                    n_front = PW'(mv_step);
                    if (r_second) begin
                        n_delta = DW'(r_tag);
                        n_state = tglc_pkg::ST_MK_START;
                    end else begin
                        n_state = tglc_pkg::ST_DISPATCH;
                    end
                end
            end
            tglc_pkg::ST_DISPATCH: begin
                n_gap   = r_cfg_ms;
                n_best  = '0;
                n_bestv = '0;
                n_prev  = '0;
                case (r_cmd)
                    tglc_pkg::CMD_PLACE: begin
                        n_delta = DW'(r_tag);
                        n_state = tglc_pkg::ST_MK_START;
                    end
                    tglc_pkg::CMD_REMOVE, tglc_pkg::CMD_ADVANCE: begin
                        n_delta = neg_c;
                        n_state = tglc_pkg::ST_MK_START;
                    end
                    tglc_pkg::CMD_GAP: begin
                        n_i     = HIW'(r_bw);
                        n_iend  = HIW'(2 * r_bw);
                        n_state = tglc_pkg::ST_HW;
                    end
                    tglc_pkg::CMD_CHANGE: begin
                        n_i     = '0;
                        n_iend  = size_c;
                        n_state = tglc_pkg::ST_HW;
                    end
                    default: n_state = tglc_pkg::ST_DONE;
                endcase
            end
            tglc_pkg::ST_BACK: begin
                if (r_bk == '0) begin
                    n_state = r_ret;
                end else begin
                    n_ptr = ptr_dec;
                    n_bk  = r_bk - BLW'(1);
                end
            end
            tglc_pkg::ST_MK_START: begin
                n_ptr   = r_front;
                n_bk    = r_blen - BLW'(1);
                n_ret   = tglc_pkg::ST_MK_RD;
                n_k     = '0;
                n_j     = '0;
                n_state = tglc_pkg::ST_BACK;
            end
            tglc_pkg::ST_MK_RD, tglc_pkg::ST_MK_WR: begin
                if (r_state == tglc_pkg::ST_MK_RD && l_mk < nl_s) begin
                    n_state = tglc_pkg::ST_MK_WR;
                end else begin
                    mem_we  = (r_state == tglc_pkg::ST_MK_WR);
                    n_state = tglc_pkg::ST_MK_RD;
                    if (r_j == r_bw - BWW'(1)) begin
                        n_j = '0;
                        if (r_k == r_blen - BLW'(1)) begin
                            n_state = tglc_pkg::ST_DONE;
                            if (!r_second && r_cmd == tglc_pkg::CMD_CHANGE) begin
                                n_second  = 1'b1;
                                n_changed = 1'b1;
                                n_lane    = r_right ? r_lane + SLW'(1) : r_lane - SLW'(1);
                                n_delta   = DW'(r_tag);
                                n_state   = tglc_pkg::ST_MK_START;
                            end else if (!r_second && r_cmd == tglc_pkg::CMD_ADVANCE) begin
                                n_second = 1'b1;
                                n_state  = tglc_pkg::ST_ADV;
                            end
                        end else begin
                            n_k   = r_k + BLW'(1);
                            n_ptr = ptr_inc;
                        end
                    end else begin
                        n_j = r_j + BWW'(1);
                    end
                end
            end
            tglc_pkg::ST_HW: begin
                if (r_i == r_iend) begin
                    n_state = (r_cmd == tglc_pkg::CMD_GAP) ? tglc_pkg::ST_DONE : tglc_pkg::ST_DEC;
                end else if (l_onroad) begin
                    n_ln    = l_cur;
                    n_ptr   = front_inc;
                    n_cnt   = '0;
                    n_state = tglc_pkg::ST_SC_RD;
                end else begin
                    hw_fin = 1'b1;
                    hw_v   = '0;
                end
            end
            tglc_pkg::ST_SC_RD: begin
                if (r_cnt < r_cfg_ms) begin
                    n_state = tglc_pkg::ST_SC_EV;
                end else begin
                    hw_fin = 1'b1;
                end
            end
            tglc_pkg::ST_SC_EV: begin
                if (mem_rdata == '0) begin
                    n_cnt   = r_cnt + 4'd1;
                    n_ptr   = ptr_inc;
                    n_state = tglc_pkg::ST_SC_RD;
                end else begin
                    hw_fin = 1'b1;
                end
            end
            tglc_pkg::ST_DEC: begin
                n_state = tglc_pkg::ST_DONE;
                if (chg_ok && (go_left || go_right)) begin
                    n_right = go_right;
                    n_tl    = go_right ? r_lane + SLW'(r_bw) : r_lane - SLW'(1);
                    n_ptr   = r_front;
                    n_bk    = r_blen - BLW'(1);
                    n_tn    = TNW'(r_blen) + TNW'(r_spd);
                    n_ret   = tglc_pkg::ST_TC_RD;
                    n_state = tglc_pkg::ST_BACK;
                end
            end
            tglc_pkg::ST_TC_RD: begin
                if (r_tn == '0) begin
                    n_delta = neg_c;
                    n_state = tglc_pkg::ST_MK_START;
                end else begin
                    n_state = tglc_pkg::ST_TC_EV;
                end
            end
            tglc_pkg::ST_TC_EV: begin
                if (mem_rdata != '0) begin
                    n_state = tglc_pkg::ST_DONE;
                end else begin
                    n_ptr   = ptr_inc;
                    n_tn    = r_tn - TNW'(1);
                    n_state = tglc_pkg::ST_TC_RD;
                end
            end
            tglc_pkg::ST_ADV: begin
                n_delta = DW'(r_tag);
                n_state = tglc_pkg::ST_MK_START;
                if (adv_sum >= VW'(len_c)) begin
                    if (r_cfg_per) begin
                        n_mv    = adv_sum;
                        n_mk    = KW'(VW - 1);
                        n_state = tglc_pkg::ST_MOD;
                    end else begin
                        n_front = lenm1;
                    end
                end else begin
                    n_front = PW'(adv_sum);
                end
            end
            tglc_pkg::ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_opos   = 10'(r_front);
                    n_olane  = r_lane[1:0];
                    n_ochg   = r_changed;
                    n_ogap   = (r_cmd == tglc_pkg::CMD_GAP || r_cmd == tglc_pkg::CMD_CHANGE) ?
                               r_gap : 4'd0;
                    n_state  = tglc_pkg::ST_IDLE;
                end
            end
            default: n_state = tglc_pkg::ST_IDLE;
        endcase

        if (hw_fin) begin
            if (l_own && l_onroad && hw_v < r_gap) begin
                n_gap = hw_v;
            end
            n_best  = b1;
            n_bestv = b1v;
            if (r_i == size_c - HIW'(1) && 5'(hw_v) > b1v) begin
                n_best  = r_i;
                n_bestv = 5'(hw_v);
            end
            n_prev  = hw_v;
            n_i     = r_i + HIW'(1);
            n_state = tglc_pkg::ST_HW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tglc_pkg::ST_CLEAR;
            r_ret    <= tglc_pkg::ST_IDLE;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_front   <= n_front;
        r_lane    <= n_lane;
        r_spd     <= n_spd;
        r_blen    <= n_blen;
        r_bw      <= n_bw;
        r_tag     <= n_tag;
        r_rnd     <= n_rnd;
        r_adv     <= n_adv;
        r_mv      <= n_mv;
        r_mk      <= n_mk;
        r_ptr     <= n_ptr;
        r_bk      <= n_bk;
        r_delta   <= n_delta;
        r_k       <= n_k;
        r_j       <= n_j;
        r_second  <= n_second;
        r_changed <= n_changed;
        r_right   <= n_right;
        r_tl      <= n_tl;
        r_cnt     <= n_cnt;
        r_ln      <= n_ln;
        r_i       <= n_i;
        r_iend    <= n_iend;
        r_prev    <= n_prev;
        r_best    <= n_best;
        r_bestv   <= n_bestv;
        r_gap     <= n_gap;
        r_tn      <= n_tn;
        r_opos    <= n_opos;
        r_olane   <= n_olane;
        r_ochg    <= n_ochg;
        r_ogap    <= n_ogap;
    end

    assign o_stall    = (r_state != tglc_pkg::ST_IDLE);
    assign o_valid    = r_ovalid;
    assign o_new_pos  = r_opos;
    assign o_new_lane = r_olane;
    assign o_changed  = r_ochg;
    assign o_gap      = r_ogap;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives place, remove, gap, lane change and advance commands into the lane
// change grid core, predicts every result from an in-bench copy of the grid
// and compares each output transfer field by field
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_LANES = 4;
    localparam int NUM_CELLS = 1024;
    localparam int WATCHDOG  = 20000;
    localparam int FLEET     = 6;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  front_pos;
        logic [1:0]  lane;
        logic [3:0]  speed;
        logic [3:0]  blen;
        logic [1:0]  bw;
        logic [14:0] tag;
        logic [15:0] rnd;
        logic [3:0]  adv;
    } t_vehicle_cmd;

    typedef struct packed {
        logic [9:0] pos;
        logic [1:0] lane;
        logic       changed;
        logic [3:0] gap;
    } t_move;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_cmd = '0;
    logic [9:0]  i_front_pos = '0;
    logic [1:0]  i_left_lane = '0;
    logic [3:0]  i_speed = '0;
    logic [3:0]  i_body_length = '0;
    logic [1:0]  i_body_width = '0;
    logic [14:0] i_tag = '0;
    logic [15:0] i_rand_req = '0;
    logic [3:0]  i_advance = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [9:0]  o_new_pos;
    logic [1:0]  o_new_lane;
    logic        o_changed;
    logic [3:0]  o_gap;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    traffic_grid_lane_change_core dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // grid copy and register copy
    logic [15:0] grid [NUM_LANES][NUM_CELLS];
    int unsigned road_len_r = 1024, lanes_r = 4, vmax_r = 5, thresh_r = 0, wrap_r = 1;

    t_move expected_moves [$];
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_cycles = 0;
    int    quiet_cycles = 0;

    int fpos [FLEET];
    int flane [FLEET];
    int flen [FLEET];
    int fwid [FLEET];
    logic [14:0] ftag [FLEET];
    bit fon [FLEET];

    function automatic int cells_in_use();
        if (road_len_r == 0) return 1;
        if (road_len_r > NUM_CELLS) return NUM_CELLS;
        return road_len_r;
    endfunction

    function automatic int lanes_in_use();
        if (lanes_r == 0) return 1;
        if (lanes_r > NUM_LANES) return NUM_LANES;
        return lanes_r;
    endfunction

    function automatic int wrap_cell(int p, int len);
        int r;
        r = p % len;
        if (r < 0) r += len;
        return r;
    endfunction

    function automatic int free_run(int lane, int front, int len);
        int n;
        n = 0;
        while (n < int'(vmax_r) && grid[lane][wrap_cell(front + 1 + n, len)] == 16'd0)
            n++;
        return n;
    endfunction

    function automatic void stamp(int front, int lane, int blen, int bw,
                                  logic [15:0] delta, int len, int nl);
        for (int k = 0; k < blen; k++)
            for (int l = lane; l < lane + bw; l++)
                if (l >= 0 && l < nl)
                    grid[l][wrap_cell(front - blen + 1 + k, len)] += delta;
    endfunction

    function automatic int lane_gap(int front, int lane, int bw, int len, int nl);
        int g, c;
        g = vmax_r;
        for (int l = lane; l < lane + bw; l++)
            if (l < nl) begin
                c = free_run(l, front, len);
                if (c < g) g = c;
            end
        return g;
    endfunction

    function automatic bit lane_clear(int tl, int front, int blen, int spd, int len);
        for (int p = front - blen + 1; p < front + spd + 1; p++)
            if (grid[tl][wrap_cell(p, len)] != 16'd0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_move predict_move(t_vehicle_cmd c);
        int len, nl, front, lane, spd, blen, bw, sz, centre, best, dir, l, g;
        int hw [6];
        logic [15:0] tg, ng;
        t_move r;
        len = cells_in_use();
        nl = lanes_in_use();
        front = int'(c.front_pos) % len;
        lane = c.lane;
        spd = c.speed;
        blen = c.blen;
        bw = c.bw;
        if (blen < 1) blen = 1;
        if (blen > 8) blen = 8;
        if (bw < 1) bw = 1;
        if (bw > 2) bw = 2;
        tg = {1'b0, c.tag};
        ng = 16'd0 - tg;
        g = 0;
        r.changed = 1'b0;
        case (c.cmd)
            tglc_pkg::CMD_PLACE: stamp(front, lane, blen, bw, tg, len, nl);
            tglc_pkg::CMD_REMOVE: stamp(front, lane, blen, bw, ng, len, nl);
            tglc_pkg::CMD_GAP: g = lane_gap(front, lane, bw, len, nl);
            tglc_pkg::CMD_CHANGE: begin
                sz = 3 * bw;
                centre = (3 * bw - 1) / 2;
                best = 0;
                dir = 0;
                for (int i = 0; i < sz; i++) begin
                    l = lane - bw + i;
                    hw[i] = (l >= 0 && l < nl) ? free_run(l, front, len) : 0;
                end
                if (bw > 1)
                    for (int i = 0; i < sz - 1; i++) hw[i] += hw[i + 1];
                for (int i = 1; i < sz; i++)
                    if (hw[i] > hw[best]) best = i;
                g = lane_gap(front, lane, bw, len, nl);
                if (c.rnd <= thresh_r && g <= spd && spd < int'(vmax_r)) begin
                    if (best < centre) begin
                        if (lane > 0 && lane - 1 < nl &&
                            lane_clear(lane - 1, front, blen, spd, len))
                            dir = -1;
                    end else if (best > centre) begin
                        if (lane + bw < nl && lane_clear(lane + bw, front, blen, spd, len))
                            dir = 1;
                    end
                    if (dir != 0) begin
                        stamp(front, lane, blen, bw, ng, len, nl);
                        lane += dir;
                        stamp(front, lane, blen, bw, tg, len, nl);
                        r.changed = 1'b1;
                    end
                end
            end
            tglc_pkg::CMD_ADVANCE: begin
                stamp(front, lane, blen, bw, ng, len, nl);
                front += c.adv;
                if (front >= len) front = wrap_r ? front % len : len - 1;
                stamp(front, lane, blen, bw, tg, len, nl);
            end
            default: ;
        endcase
        r.pos = front[9:0];
        r.lane = lane[1:0];
        r.gap = g[3:0];
        return r;
    endfunction

    // result checking
    task automatic report(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_move e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_moves.size() == 0) begin
                $display("%0t: unexpected result transfer, actual pos %0d lane %0d",
                         $time, o_new_pos, o_new_lane);
                errors++;
            end else begin
                e = expected_moves.pop_front();
                report("new_pos", e.pos, o_new_pos);
                report("new_lane", e.lane, o_new_lane);
                report("changed", e.changed, o_changed);
                report("gap", e.gap, o_gap);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_cmd(input t_vehicle_cmd c, output t_move r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c.cmd;
        i_front_pos <= c.front_pos;
        i_left_lane <= c.lane;
        i_speed <= c.speed;
        i_body_length <= c.blen;
        i_body_width <= c.bw;
        i_tag <= c.tag;
        i_rand_req <= c.rnd;
        i_advance <= c.adv;
        do @(posedge i_clk); while (o_stall);
        r = predict_move(c);
        expected_moves.push_back(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_moves.size() != 0) @(posedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[15:0];
        case (idx)
            tglc_pkg::CFG_ROAD_LENGTH: road_len_r = value & 32'h7FF;
            tglc_pkg::CFG_LANES_USED: lanes_r = value & 32'h7;
            tglc_pkg::CFG_MAX_SPEED: vmax_r = value & 32'hF;
            tglc_pkg::CFG_THRESHOLD: thresh_r = value & 32'hFFFF;
            tglc_pkg::CFG_PERIODIC: wrap_r = value & 32'h1;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_road(int unsigned rl, int unsigned nl, int unsigned vm,
                            int unsigned th, int unsigned wr);
        drain();
        write_reg(tglc_pkg::CFG_ROAD_LENGTH, rl);
        write_reg(tglc_pkg::CFG_LANES_USED, nl);
        write_reg(tglc_pkg::CFG_MAX_SPEED, vm);
        write_reg(tglc_pkg::CFG_THRESHOLD, th);
        write_reg(tglc_pkg::CFG_PERIODIC, wr);
    endtask

    function automatic t_vehicle_cmd make_cmd(logic [2:0] cmd, int pos, int lane, int spd,
                                              int blen, int bw, logic [14:0] tag,
                                              int rnd, int adv);
        t_vehicle_cmd c;
        c.cmd = cmd;
        c.front_pos = pos[9:0];
        c.lane = lane[1:0];
        c.speed = spd[3:0];
        c.blen = blen[3:0];
        c.bw = bw[1:0];
        c.tag = tag;
        c.rnd = rnd[15:0];
        c.adv = adv[3:0];
        return c;
    endfunction

    function automatic t_vehicle_cmd noise_cmd();
        logic [63:0] bits;
        t_vehicle_cmd c;
        bits = {$urandom, $urandom};
        c = bits[59:0];
        return c;
    endfunction

    function automatic t_vehicle_cmd fleet_cmd(int v, logic [2:0] cmd);
        int spd;
        spd = $urandom_range(1) ? $urandom_range(15) : $urandom_range(vmax_r > 0 ? vmax_r - 1 : 0);
        return make_cmd(cmd, fpos[v], flane[v], spd, flen[v], fwid[v], ftag[v],
                        $urandom_range(65535), $urandom_range(15));
    endfunction

    task automatic run_traffic(int n);
        t_vehicle_cmd c;
        t_move r;
        int v, op;
        for (int k = 0; k < n; k++) begin
            v = $urandom_range(FLEET - 1);
            op = $urandom_range(9);
            if ($urandom_range(9) == 0) begin
                send_cmd(noise_cmd(), r);
            end else if (!fon[v]) begin
                fpos[v] = $urandom_range(cells_in_use() - 1);
                flane[v] = $urandom_range(lanes_in_use() - 1);
                flen[v] = $urandom_range(8, 1);
                fwid[v] = $urandom_range(2, 1);
                ftag[v] = $urandom_range(32767, 1);
                send_cmd(fleet_cmd(v, tglc_pkg::CMD_PLACE), r);
                fon[v] = 1'b1;
            end else begin
                if (op == 0) c = fleet_cmd(v, tglc_pkg::CMD_REMOVE);
                else if (op < 4) c = fleet_cmd(v, tglc_pkg::CMD_GAP);
                else if (op < 7) c = fleet_cmd(v, tglc_pkg::CMD_CHANGE);
                else c = fleet_cmd(v, tglc_pkg::CMD_ADVANCE);
                send_cmd(c, r);
                fon[v] = (op != 0);
                fpos[v] = r.pos;
                flane[v] = r.lane;
            end
        end
    endtask

    task automatic clear_fleet();
        t_move r;
        for (int v = 0; v < FLEET; v++)
            if (fon[v]) begin
                send_cmd(fleet_cmd(v, tglc_pkg::CMD_REMOVE), r);
                fon[v] = 1'b0;
            end
    endtask

    // edge cases at reset settings, then clamping at the road end
    task automatic test_directed();
        t_move r;
        send_cmd(make_cmd(tglc_pkg::CMD_PLACE, 2, 3, 0, 8, 2, 15'h7FFF, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_GAP, 1020, 3, 0, 1, 1, 15'd1, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_PLACE, 100, 1, 0, 1, 1, 15'd1, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_PLACE, 102, 1, 0, 15, 0, 15'd5, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_GAP, 100, 1, 0, 1, 1, 15'd1, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_GAP, 100, 0, 0, 1, 3, 15'd1, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_CHANGE, 100, 1, 2, 1, 1, 15'd1, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_CHANGE, 102, 2, 4, 8, 2, 15'd5, 65535, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_CHANGE, 500, 0, 15, 1, 1, 15'd9, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_ADVANCE, 1020, 0, 0, 3, 2, 15'd3, 0, 15), r);
        send_cmd(make_cmd(tglc_pkg::CMD_REMOVE, 1023, 3, 0, 8, 2, 15'h4000, 0, 0), r);
        send_cmd(make_cmd(3'd5, 1023, 3, 15, 15, 3, 15'h7FFF, 65535, 15), r);
        send_cmd(make_cmd(3'd6, 0, 0, 0, 0, 0, 15'd0, 0, 0), r);
        send_cmd(make_cmd(3'd7, 512, 2, 7, 4, 1, 15'h2AAA, 21845, 5), r);
        set_road(1024, 4, 15, 65535, 0);
        send_cmd(make_cmd(tglc_pkg::CMD_PLACE, 1018, 2, 0, 4, 1, 15'd7, 0, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_ADVANCE, 1018, 2, 0, 4, 1, 15'd7, 0, 15), r);
        send_cmd(make_cmd(tglc_pkg::CMD_CHANGE, 1023, 2, 0, 4, 1, 15'd7, 65535, 0), r);
        send_cmd(make_cmd(tglc_pkg::CMD_GAP, 1000, 1, 0, 2, 2, 15'd7, 0, 0), r);
    endtask

    task automatic test_traffic(int phase, int n);
        case (phase)
            0: set_road(1024, 4, 5, 65535, 1);
            1: set_road(16, 3, 15, 32768, 0);
            2: set_road(1, 1, 1, 0, 1);
            3: set_road(2047, 7, 0, 65535, 0);
            4: set_road(0, 0, 15, 65535, 1);
            default: set_road(40, 2, 8, 65535, 1);
        endcase
        run_traffic(n);
        clear_fleet();
    endtask

    // receiver holds off while commands keep coming
    task automatic test_backpressure();
        hold_cycles = 1500;
        run_traffic(30);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 65;
        test_directed();
        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle_pct = 65;
                recv_idle_pct = 37;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            test_traffic(p, 200);
        end
        test_backpressure();
        drain();
        if (errors == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tglc_pkg.sv
hw/rtl/tglc_grid_mem.sv
hw/rtl/traffic_grid_lane_change_core.sv
tb/testbench.sv
